>>> rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring fifo with search
// commands, register indexes, packing of the stream words and the control
// bundle between the sequencer and the window compare unit
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    typedef logic [7:0] brf_byte_t;

    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_POP       = 2'd1,
        CMD_FIND_BYTE = 2'd2,
        CMD_FIND_PAT  = 2'd3
    } brf_cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } brf_state_t;

    // input word, lowest bits first: cmd, data
    typedef struct packed {
        logic [5:0] pad;
        brf_byte_t  data;
        brf_cmd_t   cmd;
    } brf_cmd_word_t;

    // result word, lowest bits first: ok, out_byte, match_offset, fill_count,
    // is_empty
    typedef struct packed {
        logic [5:0] pad;
        logic       is_empty;
        brf_byte_t  fill_count;
        brf_byte_t  match_offset;
        brf_byte_t  out_byte;
        logic       ok;
    } brf_result_t;

    // sequencer to window compare unit
    typedef struct packed {
        logic      load;       // latch key and length, empty the window
        logic      find_byte;  // single byte key from data
        logic      shift;      // a queued byte arrives
        brf_byte_t data;
    } brf_win_ctl_t;

endpackage

>>> rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram: generic single clock ram
// one write port, one read port with enable and registered read data
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/brf_match.sv
// ----------------------------------------------------------------------------
// brf_match: sliding window compare
// holds the search key in reverse order and the last bytes read from the
// queue, and flags a hit when the newest bytes equal the key
// ----------------------------------------------------------------------------
module brf_match import brf_pkg::*; #(
    parameter int PATTERN_MAX = 8
) (
    input  logic                  aclk,
    input  brf_win_ctl_t          ctl,
    input  logic [CFG_DATA_W-1:0] pattern_bytes,
    input  logic [3:0]            pattern_length,
    output logic                  hit,
    output logic [2:0]            span
);

    localparam logic [3:0] PAT_MAX = 4'(PATTERN_MAX);

    brf_byte_t              key_reg  [PATTERN_MAX];
    brf_byte_t              key_next [PATTERN_MAX];
    brf_byte_t              win_reg  [PATTERN_MAX];
    brf_byte_t              win_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] mask_reg, mask_next;
    logic [PATTERN_MAX-1:0] wv_reg, wv_next;
    logic [2:0]             span_reg, span_next;
    logic [2:0]             pidx [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] lane_ok;
    logic [3:0]             len_raw, len, len_m1;

    always_comb begin
        // zero length counts as one, longer than the window saturates
        len_raw = ctl.find_byte ? 4'd1 : pattern_length;
        if (len_raw == 4'd0) begin
            len = 4'd1;
        end else if (len_raw > PAT_MAX) begin
            len = PAT_MAX;
        end else begin
            len = len_raw;
        end
        len_m1 = len - 4'd1;

        key_next  = key_reg;
        mask_next = mask_reg;
        span_next = span_reg;
        win_next  = win_reg;
        wv_next   = wv_reg;

        // window slot m holds the byte m places back, so it meets key byte len-1-m
        for (int m = 0; m < PATTERN_MAX; m++) begin
            pidx[m] = 3'(len_m1 - 4'(m));
        end

        if (ctl.load) begin
            for (int m = 0; m < PATTERN_MAX; m++) begin
                key_next[m]  = pattern_bytes[{pidx[m], 3'b000} +: 8];
                mask_next[m] = (4'(m) < len);
            end
            if (ctl.find_byte) begin
                key_next[0] = ctl.data;
            end
            span_next = 3'(len_m1);
            wv_next   = '0;
        end else if (ctl.shift) begin
            win_next[0] = ctl.data;
            wv_next[0]  = 1'b1;
            for (int m = 1; m < PATTERN_MAX; m++) begin
                win_next[m] = win_reg[m-1];
                wv_next[m]  = wv_reg[m-1];
            end
        end

        // compare on the window as it stands with the arriving byte
        for (int m = 0; m < PATTERN_MAX; m++) begin
            lane_ok[m] = !mask_reg[m] || (wv_next[m] && (win_next[m] == key_reg[m]));
        end
        hit = ctl.shift && (&lane_ok);
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        mask_reg <= mask_next;
        span_reg <= span_next;
        win_reg  <= win_next;
        wv_reg   <= wv_next;
    end

    assign span = span_reg;

endmodule

>>> rtl/byte_ring_fifo_with_search_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_unit: byte ring fifo with byte and pattern search
// circular byte queue in one ram with push, pop, find byte and find pattern
// commands, one result transfer per command
// ----------------------------------------------------------------------------
// The queue keeps one slot free and so holds up to DEPTH-1 bytes in a single
// synchronous ram. Commands are taken one at a time: s_tready is high only
// while no command is in flight. Push and pop go to the result state on the
// command transfer (pop reads the ram in that cycle), m_tvalid is registered
// from the result state, and s_tready comes back in the same cycle as
// m_tvalid. Find byte and find pattern read the queue from the head one byte
// per cycle through the ram's single read port and compare the newest bytes
// against the key in a window of PATTERN_MAX bytes; they go to the result
// state on a hit, or on a miss once the last of the fill count of queued
// bytes is compared, or at once when the queue is empty, and s_tready again
// comes back with m_tvalid. A held result waits in the result state until
// m_tready takes it. Searches leave the queue as it is. The pattern registers
// are written through the cfg channel, which is always ready, and are meant
// to change only while no command is in flight.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search_unit import brf_pkg::*; #(
    parameter int DEPTH       = 256,
    parameter int PATTERN_MAX = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // command stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // cmd[1:0], data[9:2], zeros above
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // ok[0], out_byte[8:1],
                                               // match_offset[16:9],
                                               // fill_count[24:17], is_empty[25]
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,  // 0 pattern_bytes, 1 pattern_length
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int              AW   = $clog2(DEPTH);
    localparam int              OW   = (AW > 4) ? AW : 4;
    localparam logic [AW-1:0]   LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // sequencer state
    brf_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;   // next slot to read in a search
    logic [AW-1:0] rd_cnt_reg, rd_cnt_next;     // bytes read so far
    logic [AW-1:0] cmp_cnt_reg, cmp_cnt_next;   // offset of the byte now arriving
    logic          rd_pend_reg, rd_pend_next;   // ram data valid this cycle

    // result being built and the output register
    logic          res_ok_reg, res_ok_next;
    logic          res_pop_reg, res_pop_next;
    brf_byte_t     res_off_reg, res_off_next;
    logic          m_valid_reg, m_valid_next;
    brf_result_t   m_data_reg, m_data_next;

    // pattern registers
    logic [CFG_DATA_W-1:0] pat_bytes_reg, pat_bytes_next;
    logic [3:0]            pat_len_reg, pat_len_next;

    // ram ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    brf_byte_t     ram_wdata, ram_rdata;

    // window compare unit
    brf_win_ctl_t  win_ctl;
    logic          win_hit;
    logic [2:0]    win_span;

    brf_cmd_word_t in_word;
    logic          issue;

    assign in_word   = brf_cmd_word_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brf_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .aclk           (aclk),
        .ctl            (win_ctl),
        .pattern_bytes  (pat_bytes_reg),
        .pattern_length (pat_len_reg),
        .hit            (win_hit),
        .span           (win_span)
    );

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        rd_addr_next = rd_addr_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmp_cnt_next = cmp_cnt_reg;
        rd_pend_next = rd_pend_reg;
        res_ok_next  = res_ok_reg;
        res_pop_next = res_pop_reg;
        res_off_next = res_off_reg;
        m_data_next  = m_data_reg;
        // output register empties when the sink takes the transfer
        m_valid_next = m_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = in_word.data;
        ram_re    = 1'b0;
        ram_raddr = head_reg;
        win_ctl   = '0;
        issue     = 1'b0;

        // register writes
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pat_bytes_next = cfg_data;
                CFG_PATTERN_LENGTH: pat_len_next   = cfg_data[3:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_ok_next  = 1'b0;
                    res_pop_next = 1'b0;
                    res_off_next = '0;
                    state_next   = ST_RESULT;
                    case (in_word.cmd)
                        CMD_PUSH: begin
                            // one slot always stays free
                            if (fill_reg != LAST) begin
                                ram_we      = 1'b1;
                                tail_next   = wrap_inc(tail_reg);
                                fill_next   = fill_reg + 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            // head byte is read now and shown from the ram output
                            if (fill_reg != '0) begin
                                ram_re       = 1'b1;
                                head_next    = wrap_inc(head_reg);
                                fill_next    = fill_reg - 1'b1;
                                res_ok_next  = 1'b1;
                                res_pop_next = 1'b1;
                            end
                        end
                        CMD_FIND_BYTE, CMD_FIND_PAT: begin
                            win_ctl.load      = 1'b1;
                            win_ctl.find_byte = (in_word.cmd == CMD_FIND_BYTE);
                            win_ctl.data      = in_word.data;
                            rd_addr_next      = head_reg;
                            rd_cnt_next       = '0;
                            cmp_cnt_next      = '0;
                            rd_pend_next      = 1'b0;
                            if (fill_reg != '0) begin
                                state_next = ST_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SEARCH: begin
                // keep the read port busy until every queued byte is read
                issue = (rd_cnt_reg != fill_reg);
                if (issue) begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_addr_reg;
                    rd_addr_next = wrap_inc(rd_addr_reg);
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
                rd_pend_next = issue;
                if (rd_pend_reg) begin
                    win_ctl.shift = 1'b1;
                    win_ctl.data  = ram_rdata;
                    if (win_hit) begin
                        // match starts span bytes before the newest one
                        res_ok_next  = 1'b1;
                        res_off_next = 8'(OW'(cmp_cnt_reg) - OW'(win_span));
                        rd_pend_next = 1'b0;
                        state_next   = ST_RESULT;
                    end else if (cmp_cnt_reg == fill_reg - 1'b1) begin
                        // last queued byte seen without a match
                        rd_pend_next = 1'b0;
                        state_next   = ST_RESULT;
                    end else begin
                        cmp_cnt_next = cmp_cnt_reg + 1'b1;
                    end
                end
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.pad           = '0;
                    m_data_next.ok            = res_ok_reg;
                    m_data_next.out_byte      = res_pop_reg ? ram_rdata : 8'd0;
                    m_data_next.match_offset  = res_off_reg;
                    m_data_next.fill_count    = 8'(fill_reg);
                    m_data_next.is_empty      = (fill_reg == '0);
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            pat_bytes_reg <= '0;
            pat_len_reg   <= 4'd1;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        rd_cnt_reg  <= rd_cnt_next;
        cmp_cnt_reg <= cmp_cnt_next;
        res_ok_reg  <= res_ok_next;
        res_pop_reg <= res_pop_next;
        res_off_reg <= res_off_next;
        m_data_reg  <= m_data_next;
    end

    // distance from head to tail around the ring, for checking
    logic [AW:0] ring_diff, ring_span;
    assign ring_diff = {1'b0, tail_reg} - {1'b0, head_reg};
    assign ring_span = ring_diff[AW] ? ring_diff + (AW+1)'(DEPTH) : ring_diff;

    // fill count always agrees with the pointers
    assert property (@(posedge aclk) disable iff (!aresetn)
        AW'(ring_span) == fill_reg)
        else $error("fill count out of step with head and tail");

    // queue never grows past the free slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LAST)
        else $error("fill count beyond capacity");

    // the store is written only by a push taken in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE && s_tvalid && in_word.cmd == CMD_PUSH))
        else $error("store written outside a push");

    // one command in flight: a taken command blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while one is in flight");

endmodule
